[hw/rtl/sdspi_pkg.sv]
// Shared types and constants for the SD card SPI-mode host sequencer.
// No dependencies; imported by every module of the block.
package sdspi_pkg;

    localparam int CNT_W       = 17;
    localparam int BLOCK_BYTES = 512;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    // host command codes
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;
    localparam logic [1:0] CMD_DELAY = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DUMMY_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_POLL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TRIES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_POLL   = 3'd4;

    // completion status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_RESET_FAIL    = 2'd1;
    localparam logic [1:0] ST_IFCOND_REJECT = 2'd2;
    localparam logic [1:0] ST_BAD_ECHO      = 2'd3;
    localparam logic [1:0] ST_READ_REJECT   = 2'd1;
    localparam logic [1:0] ST_TOKEN_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] block_address;
        logic [7:0]  rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_active;
        logic [7:0] delay_request_ms;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       data_last;
        logic       done_res;
        logic [1:0] status;
    } out_word_t;

    // effective limits, zero already promoted to one (retry_delay is passed through unchanged)
    typedef struct packed {
        logic [4:0]       dummy_lim;
        logic [7:0]       reply_lim;
        logic [5:0]       attempt_lim;
        logic [7:0]       retry_delay;
        logic [CNT_W-1:0] token_lim;
    } cfg_t;

endpackage

[hw/rtl/sdspi_cfg.sv]
// Configuration register file for the SD SPI host sequencer.
// Depends on sdspi_pkg; feeds effective limits to sdspi_seq.
module sdspi_cfg
    import sdspi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic [4:0]       dummy_reg;
    logic [7:0]       reply_reg;
    logic [5:0]       attempt_reg;
    logic [7:0]       delay_reg;
    logic [CNT_W-1:0] token_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dummy_reg   <= 5'd10;
            reply_reg   <= 8'd100;
            attempt_reg <= 6'd50;
            delay_reg   <= 8'd10;
            token_reg   <= 17'd100000;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_DUMMY_BYTES: dummy_reg   <= wr_data[4:0];
                CFG_REPLY_POLL:  reply_reg   <= wr_data[7:0];
                CFG_RESET_TRIES: attempt_reg <= wr_data[5:0];
                CFG_RETRY_DELAY: delay_reg   <= wr_data[7:0];
                CFG_TOKEN_POLL:  token_reg   <= wr_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.dummy_lim   = (dummy_reg == '0) ? 5'd1 : dummy_reg;
        cfg.reply_lim   = (reply_reg == '0) ? 8'd1 : reply_reg;
        cfg.attempt_lim = (attempt_reg == '0) ? 6'd1 : attempt_reg;
        cfg.retry_delay = delay_reg;
        cfg.token_lim   = (token_reg == '0) ? 17'd1 : token_reg;
    end

endmodule

[hw/rtl/sdspi_seq.sv]
// Protocol sequencer: phase state, counters and next-word logic.
// Depends on sdspi_pkg; state advances when the top level issues step.
module sdspi_seq
    import sdspi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_word_t  item,
    input  cfg_t      cfg,
    output out_word_t res
);

    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_DUMMY  = 5'd1;
    localparam logic [4:0] PH_SEND0  = 5'd2;
    localparam logic [4:0] PH_POLL0  = 5'd3;
    localparam logic [4:0] PH_TAIL0  = 5'd4;
    localparam logic [4:0] PH_WAIT0  = 5'd5;
    localparam logic [4:0] PH_SEND8  = 5'd6;
    localparam logic [4:0] PH_POLL8  = 5'd7;
    localparam logic [4:0] PH_R7     = 5'd8;
    localparam logic [4:0] PH_TAIL8  = 5'd9;
    localparam logic [4:0] PH_SEND55 = 5'd10;
    localparam logic [4:0] PH_POLL55 = 5'd11;
    localparam logic [4:0] PH_TAIL55 = 5'd12;
    localparam logic [4:0] PH_SEND41 = 5'd13;
    localparam logic [4:0] PH_POLL41 = 5'd14;
    localparam logic [4:0] PH_TAIL41 = 5'd15;
    localparam logic [4:0] PH_SEND58 = 5'd16;
    localparam logic [4:0] PH_POLL58 = 5'd17;
    localparam logic [4:0] PH_OCR58  = 5'd18;
    localparam logic [4:0] PH_TAIL58 = 5'd19;
    localparam logic [4:0] PH_SEND17 = 5'd20;
    localparam logic [4:0] PH_POLL17 = 5'd21;
    localparam logic [4:0] PH_TOKEN  = 5'd22;
    localparam logic [4:0] PH_DATA   = 5'd23;
    localparam logic [4:0] PH_CRC    = 5'd24;
    localparam logic [4:0] PH_TAILRD = 5'd25;

    localparam logic [5:0] SDC_GO_IDLE    = 6'd0;
    localparam logic [5:0] SDC_IF_COND    = 6'd8;
    localparam logic [5:0] SDC_OP_COND    = 6'd41;
    localparam logic [5:0] SDC_APP        = 6'd55;
    localparam logic [5:0] SDC_READ_OCR   = 6'd58;
    localparam logic [5:0] SDC_READ_BLOCK = 6'd17;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] TOKEN_DATA = 8'hFE;
    localparam logic [7:0] ECHO_CHECK = 8'hAA;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_READY   = 8'h00;

    function automatic logic [5:0] cmd_of(input logic [4:0] ph);
        case (ph)
            PH_SEND8,  PH_POLL8:  cmd_of = SDC_IF_COND;
            PH_SEND55, PH_POLL55: cmd_of = SDC_APP;
            PH_SEND41, PH_POLL41: cmd_of = SDC_OP_COND;
            PH_SEND58, PH_POLL58: cmd_of = SDC_READ_OCR;
            PH_SEND17, PH_POLL17: cmd_of = SDC_READ_BLOCK;
            default:              cmd_of = SDC_GO_IDLE;
        endcase
    endfunction

    function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic [2:0] k,
                                              input logic [31:0] addr);
        logic [31:0] arg;
        logic [7:0]  crc;
        arg = 32'd0;
        crc = 8'h01;
        case (cmd)
            SDC_GO_IDLE:    crc = 8'h95;
            SDC_IF_COND:
            begin
                arg = 32'h0000_01AA;
                crc = 8'h87;
            end
            SDC_OP_COND:    arg = 32'h4000_0000;
            SDC_READ_BLOCK: arg = addr;
            default: ;
        endcase
        case (k)
            3'd0:    frame_byte = {2'b01, cmd};
            3'd1:    frame_byte = arg[31:24];
            3'd2:    frame_byte = arg[23:16];
            3'd3:    frame_byte = arg[15:8];
            3'd4:    frame_byte = arg[7:0];
            default: frame_byte = crc;
        endcase
    endfunction

    function automatic logic select_level(input logic [4:0] ph);
        case (ph)
            PH_IDLE, PH_DUMMY, PH_WAIT0, PH_TAIL0, PH_TAIL8,
            PH_TAIL55, PH_TAIL41, PH_TAIL58, PH_TAILRD: select_level = 1'b0;
            default:                                    select_level = 1'b1;
        endcase
    endfunction

    function automatic logic is_send(input logic [4:0] ph);
        is_send = (ph == PH_SEND0) || (ph == PH_SEND8) || (ph == PH_SEND55) ||
                  (ph == PH_SEND41) || (ph == PH_SEND58) || (ph == PH_SEND17);
    endfunction

    logic [4:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [5:0]       att_reg, att_next;
    logic [31:0]      addr_reg, addr_next;
    logic [7:0]       reply_reg, reply_next;
    logic [7:0]       echo_reg, echo_next;

    logic [CNT_W-1:0] cnt_inc;
    logic [5:0]       att_inc;
    logic [4:0]       start_ph;
    logic             do_start;
    logic             do_finish;
    logic [1:0]       fin_status;
    logic             do_ff;
    logic             ff_sel;

    assign cnt_inc = cnt_reg + 17'd1;
    assign att_inc = att_reg + 6'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        att_next   = att_reg;
        addr_next  = addr_reg;
        reply_next = reply_reg;
        echo_next  = echo_reg;
        res        = '0;
        do_start   = 1'b0;
        start_ph   = PH_SEND0;
        do_finish  = 1'b0;
        fin_status = ST_OK;
        do_ff      = 1'b0;
        ff_sel     = 1'b0;

        case (item.command)
            CMD_INIT:
            begin
                att_next   = '0;
                reply_next = BYTE_IDLE;
                echo_next  = '0;
                phase_next = PH_DUMMY;
                cnt_next   = '0;
                do_ff      = 1'b1;
            end
            CMD_READ:
            begin
                addr_next = item.block_address;
                do_start  = 1'b1;
                start_ph  = PH_SEND17;
            end
            CMD_DELAY:
            begin
                if (phase_reg == PH_WAIT0)
                    do_start = 1'b1;
                else
                    res.select_active = select_level(phase_reg);
            end
            default:
            begin
                if (phase_reg == PH_IDLE || phase_reg == PH_WAIT0)
                begin
                    res = '0;
                end
                else if (is_send(phase_reg))
                begin
                    if (cnt_inc < 17'd6)
                    begin
                        cnt_next          = cnt_inc;
                        res.tx_valid      = 1'b1;
                        res.tx_byte       = frame_byte(cmd_of(phase_reg), cnt_inc[2:0], addr_reg);
                        res.select_active = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 5'd1;
                        cnt_next   = '0;
                        do_ff      = 1'b1;
                        ff_sel     = 1'b1;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_DUMMY:
                        begin
                            cnt_next = cnt_inc;
                            if (cnt_inc >= {12'd0, cfg.dummy_lim})
                                do_start = 1'b1;
                            else
                                do_ff = 1'b1;
                        end
                        PH_POLL0, PH_POLL8, PH_POLL55, PH_POLL41, PH_POLL58, PH_POLL17:
                        begin
                            cnt_next   = cnt_inc;
                            reply_next = item.rx_byte;
                            if (item.rx_byte != BYTE_IDLE || cnt_inc >= {9'd0, cfg.reply_lim})
                            begin
                                cnt_next = '0;
                                case (phase_reg)
                                    PH_POLL0:
                                    begin
                                        phase_next = PH_TAIL0;
                                        do_ff      = 1'b1;
                                    end
                                    PH_POLL8:
                                    begin
                                        do_ff = 1'b1;
                                        if (item.rx_byte == R1_IDLE)
                                        begin
                                            phase_next = PH_R7;
                                            ff_sel     = 1'b1;
                                        end
                                        else
                                            phase_next = PH_TAIL8;
                                    end
                                    PH_POLL55:
                                    begin
                                        phase_next = PH_TAIL55;
                                        do_ff      = 1'b1;
                                    end
                                    PH_POLL41:
                                    begin
                                        phase_next = PH_TAIL41;
                                        do_ff      = 1'b1;
                                    end
                                    PH_POLL58:
                                    begin
                                        phase_next = PH_OCR58;
                                        do_ff      = 1'b1;
                                        ff_sel     = 1'b1;
                                    end
                                    default:
                                    begin
                                        if (item.rx_byte != R1_READY)
                                        begin
                                            do_finish  = 1'b1;
                                            fin_status = ST_READ_REJECT;
                                        end
                                        else
                                        begin
                                            phase_next = PH_TOKEN;
                                            do_ff      = 1'b1;
                                            ff_sel     = 1'b1;
                                        end
                                    end
                                endcase
                            end
                            else
                            begin
                                do_ff  = 1'b1;
                                ff_sel = 1'b1;
                            end
                        end
                        PH_TAIL0:
                        begin
                            if (reply_reg == R1_IDLE)
                            begin
                                do_start = 1'b1;
                                start_ph = PH_SEND8;
                            end
                            else
                            begin
                                att_next = att_inc;
                                if (att_inc >= cfg.attempt_lim)
                                begin
                                    do_finish  = 1'b1;
                                    fin_status = ST_RESET_FAIL;
                                end
                                else if (cfg.retry_delay != '0)
                                begin
                                    phase_next           = PH_WAIT0;
                                    res.delay_request_ms = cfg.retry_delay;
                                end
                                else
                                    do_start = 1'b1;
                            end
                        end
                        PH_R7, PH_OCR58:
                        begin
                            do_ff = 1'b1;
                            if (phase_reg == PH_R7)
                                echo_next = item.rx_byte;
                            if (cnt_inc < 17'd4)
                            begin
                                cnt_next = cnt_inc;
                                ff_sel   = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                phase_next = (phase_reg == PH_R7) ? PH_TAIL8 : PH_TAIL58;
                            end
                        end
                        PH_TAIL8:
                        begin
                            if (reply_reg != R1_IDLE)
                            begin
                                do_finish  = 1'b1;
                                fin_status = ST_IFCOND_REJECT;
                            end
                            else if (echo_reg != ECHO_CHECK)
                            begin
                                do_finish  = 1'b1;
                                fin_status = ST_BAD_ECHO;
                            end
                            else
                            begin
                                do_start = 1'b1;
                                start_ph = PH_SEND55;
                            end
                        end
                        PH_TAIL55:
                        begin
                            do_start = 1'b1;
                            start_ph = (reply_reg > R1_IDLE) ? PH_SEND55 : PH_SEND41;
                        end
                        PH_TAIL41:
                        begin
                            do_start = 1'b1;
                            start_ph = (reply_reg == R1_READY) ? PH_SEND58 : PH_SEND55;
                        end
                        PH_TOKEN:
                        begin
                            cnt_next = cnt_inc;
                            if (item.rx_byte == TOKEN_DATA)
                            begin
                                phase_next = PH_DATA;
                                cnt_next   = '0;
                                do_ff      = 1'b1;
                                ff_sel     = 1'b1;
                            end
                            else if (cnt_inc >= cfg.token_lim)
                            begin
                                do_finish  = 1'b1;
                                fin_status = ST_TOKEN_TIMEOUT;
                            end
                            else
                            begin
                                do_ff  = 1'b1;
                                ff_sel = 1'b1;
                            end
                        end
                        PH_DATA:
                        begin
                            res.tx_valid      = 1'b1;
                            res.tx_byte       = BYTE_IDLE;
                            res.select_active = 1'b1;
                            res.data_valid    = 1'b1;
                            res.data_byte     = item.rx_byte;
                            cnt_next          = cnt_inc;
                            if (cnt_inc >= CNT_W'(BLOCK_BYTES))
                            begin
                                res.data_last = 1'b1;
                                phase_next    = PH_CRC;
                                cnt_next      = '0;
                            end
                        end
                        PH_CRC:
                        begin
                            do_ff = 1'b1;
                            if (cnt_inc < 17'd2)
                            begin
                                cnt_next = cnt_inc;
                                ff_sel   = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                phase_next = PH_TAILRD;
                            end
                        end
                        PH_TAIL58, PH_TAILRD:
                        begin
                            do_finish  = 1'b1;
                            fin_status = ST_OK;
                        end
                        default:
                        begin
                            res.select_active = select_level(phase_reg);
                        end
                    endcase
                end
            end
        endcase

        if (do_ff)
        begin
            res.tx_valid      = 1'b1;
            res.tx_byte       = BYTE_IDLE;
            res.select_active = ff_sel;
        end
        if (do_start)
        begin
            phase_next        = start_ph;
            cnt_next          = '0;
            res               = '0;
            res.tx_valid      = 1'b1;
            res.tx_byte       = {2'b01, cmd_of(start_ph)};
            res.select_active = 1'b1;
        end
        if (do_finish)
        begin
            phase_next   = PH_IDLE;
            cnt_next     = '0;
            res          = '0;
            res.done_res = 1'b1;
            res.status   = fin_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            att_reg   <= '0;
            addr_reg  <= '0;
            reply_reg <= BYTE_IDLE;
            echo_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            att_reg   <= att_next;
            addr_reg  <= addr_next;
            reply_reg <= reply_next;
            echo_reg  <= echo_next;
        end
    end

endmodule

[hw/rtl/sd_spi_host_init_and_block_read.sv]
// Top level of the SD card SPI-mode host sequencer (init and single block read).
// Depends on sdspi_pkg, sdspi_cfg and sdspi_seq.
//
// Each input word (start init, start read, received byte, delay elapsed) yields
// exactly one result word: the next byte to send, the chip-select level, an
// optional delay request, an optional block data byte and the completion status.
// Words pass an input register and then a result register, and the block takes
// one word every clock while the result side keeps up; the phase update sets
// that rate.
// Configuration writes are taken at any time (cfg_ready is always high) but
// belong only in idle periods.
module sd_spi_host_init_and_block_read
    import sdspi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    in_word_t  in_reg;
    logic      in_v_reg;
    out_word_t out_reg;
    logic      out_v_reg;
    out_word_t seq_res;
    logic      step;

    assign cfg_ready = 1'b1;
    assign step      = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready  = !in_v_reg || step;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    sdspi_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sdspi_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_v_reg <= in_valid;
            if (step)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
        if (step)
            out_reg <= seq_res;
    end

endmodule
